FILE: rtl/core/gcpg_pkg.sv
package gcpg_pkg;

  // Coordinate arithmetic width; origins and sums wrap here
  localparam int unsigned COORD_BITS = 11;

  localparam int unsigned PIX_W     = 11;
  localparam int unsigned RECT_W    = 8;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned BPP_W     = 6;
  localparam int unsigned STEP_W    = 8;
  localparam int unsigned LAYOUT_W  = 30;
  localparam int unsigned FIELD_W   = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam int unsigned PROD_W    = 2 * RECT_W;          // row * rectangles
  localparam int unsigned ADV_W     = RECT_W + 1;          // col + row
  localparam int unsigned CH_PROD_W = ADV_W + STEP_W;      // advance * step
  localparam int unsigned IDX_PROD_W = PROD_W + STEP_W;    // cell index * step

  localparam logic [RECT_W-1:0]   RECT_RST   = RECT_W'(1);
  localparam logic [SIZE_W-1:0]   WIDTH_RST  = SIZE_W'(1);
  localparam logic [SIZE_W-1:0]   HEIGHT_RST = SIZE_W'(1);
  localparam logic [BPP_W-1:0]    BPP_RST    = BPP_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECTANGLES     = 3'd0,
    CFG_CELL_WIDTH     = 3'd1,
    CFG_CELL_HEIGHT    = 3'd2,
    CFG_COLOR_MODEL    = 3'd3,
    CFG_BITS_PER_PIXEL = 3'd4,
    CFG_FIRST_COLOR    = 3'd5,
    CFG_COLOR_STEP     = 3'd6,
    CFG_CHANNEL_LAYOUT = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [RECT_W-1:0] row;
    logic [RECT_W-1:0] col;
    logic [PIX_W-1:0]  x;
    logic [PIX_W-1:0]  y;
    logic              last;
  } s1_t;

  typedef struct packed {
    logic [PROD_W-1:0]    row_rect;
    logic [RECT_W-1:0]    col;
    logic [CH_PROD_W-1:0] red_adv;
    logic [CH_PROD_W-1:0] green_adv;
    logic [CH_PROD_W-1:0] blue_adv;
    logic [PIX_W-1:0]     x;
    logic [PIX_W-1:0]     y;
    logic                 last;
  } s2_t;

  typedef struct packed {
    logic [IDX_PROD_W-1:0] idx_prod;
    logic [COLOR_W-1:0]    direct;
    logic [PIX_W-1:0]      x;
    logic [PIX_W-1:0]      y;
    logic                  last;
  } s3_t;

  function automatic logic [COLOR_W-1:0] bpp_mask(input logic [BPP_W-1:0] bpp);
    logic [COLOR_W-1:0] m;
    if (bpp >= BPP_W'(COLOR_W)) begin
      m = '1;
    end else begin
      m = (COLOR_W'(1) << bpp[FIELD_W-1:0]) - COLOR_W'(1);
    end
    return m;
  endfunction

  // One packed channel: start from its field of first, add, wrap, place
  function automatic logic [COLOR_W-1:0] channel(
    input logic [COLOR_W-1:0]   first,
    input logic [FIELD_W-1:0]   size,
    input logic [FIELD_W-1:0]   pos,
    input logic [CH_PROD_W-1:0] adv
  );
    logic [COLOR_W-1:0] m;
    logic [COLOR_W-1:0] start;
    logic [COLOR_W-1:0] v;
    m     = (COLOR_W'(1) << size) - COLOR_W'(1);
    start = (first >> pos) & m;
    v     = (start + COLOR_W'(adv)) & m;
    return v << pos;
  endfunction

endpackage

FILE: rtl/core/grid_color_pattern_generator.sv
// Grid colour test pattern source. Each accepted request yields one pixel write
// (x, y, colour, frame_last) walking a rectangles x rectangles grid of cells in
// row-major order, lines top to bottom and pixels left to right inside a cell;
// restart_i returns the walk to the first pixel before that pixel is produced.
// One request is taken per clock and one pixel leaves per clock while nothing
// stalls; each request passes through four register stages in order (walk
// position, cell index product, index times step, output), the depth being set
// by the colour path. Configuration writes are always ready and must be
// issued only while no pixel is in flight.
module grid_color_pattern_generator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [gcpg_pkg::PIX_W-1:0]         pixel_x_o,
  output logic [gcpg_pkg::PIX_W-1:0]         pixel_y_o,
  output logic [gcpg_pkg::COLOR_W-1:0]       pixel_color_o,
  output logic                               frame_last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [gcpg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gcpg_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  localparam int unsigned CW = gcpg_pkg::COORD_BITS;
  localparam int unsigned RW = gcpg_pkg::RECT_W;
  localparam int unsigned SW = gcpg_pkg::SIZE_W;
  localparam int unsigned FW = gcpg_pkg::FIELD_W;

  // Configuration registers
  logic [RW-1:0]                     rect_q;
  logic [SW-1:0]                     cell_w_q;
  logic [SW-1:0]                     cell_h_q;
  logic                              model_q;
  logic [gcpg_pkg::BPP_W-1:0]        bpp_q;
  logic [gcpg_pkg::COLOR_W-1:0]      first_q;
  logic [gcpg_pkg::STEP_W-1:0]       step_q;
  logic [gcpg_pkg::LAYOUT_W-1:0]     layout_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_q   <= gcpg_pkg::RECT_RST;
      cell_w_q <= gcpg_pkg::WIDTH_RST;
      cell_h_q <= gcpg_pkg::HEIGHT_RST;
      model_q  <= 1'b0;
      bpp_q    <= gcpg_pkg::BPP_RST;
      first_q  <= '0;
      step_q   <= '0;
      layout_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (gcpg_pkg::cfg_reg_e'(cfg_index_i))
        gcpg_pkg::CFG_RECTANGLES:     rect_q   <= cfg_data_i[RW-1:0];
        gcpg_pkg::CFG_CELL_WIDTH:     cell_w_q <= cfg_data_i[SW-1:0];
        gcpg_pkg::CFG_CELL_HEIGHT:    cell_h_q <= cfg_data_i[SW-1:0];
        gcpg_pkg::CFG_COLOR_MODEL:    model_q  <= cfg_data_i[0];
        gcpg_pkg::CFG_BITS_PER_PIXEL: bpp_q    <= cfg_data_i[gcpg_pkg::BPP_W-1:0];
        gcpg_pkg::CFG_FIRST_COLOR:    first_q  <= cfg_data_i[gcpg_pkg::COLOR_W-1:0];
        gcpg_pkg::CFG_COLOR_STEP:     step_q   <= cfg_data_i[gcpg_pkg::STEP_W-1:0];
        gcpg_pkg::CFG_CHANNEL_LAYOUT: layout_q <= cfg_data_i[gcpg_pkg::LAYOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero sizes act as one
  logic [RW-1:0] rect_eff;
  logic [SW-1:0] w_eff;
  logic [SW-1:0] h_eff;
  assign rect_eff = (rect_q == '0) ? RW'(1) : rect_q;
  assign w_eff    = (cell_w_q == '0) ? SW'(1) : cell_w_q;
  assign h_eff    = (cell_h_q == '0) ? SW'(1) : cell_h_q;

  // Pipeline handshake: each stage fills when empty or when it moves on
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic out_rdy, s3_rdy, s2_rdy, s1_rdy, in_acc;

  assign out_rdy    = !out_v_q || !out_stall_i;
  assign s3_rdy     = !s3_v_q || out_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_acc     = in_valid_i && s1_rdy;
  assign in_stall_o = !s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_q  <= in_valid_i;
      if (s2_rdy)  s2_v_q  <= s1_v_q;
      if (s3_rdy)  s3_v_q  <= s2_v_q;
      if (out_rdy) out_v_q <= s3_v_q;
    end
  end

  // Walk position
  logic [RW-1:0] row_q, col_q, row_d, col_d;
  logic [SW-1:0] line_q, pix_q, line_d, pix_d;
  logic [CW-1:0] org_x_q, org_y_q, org_x_d, org_y_d;

  logic [RW-1:0] cur_row, cur_col;
  logic [SW-1:0] cur_line, cur_pix;
  logic [CW-1:0] cur_org_x, cur_org_y;
  logic          end_px, end_ln, end_col, end_row;
  logic [CW-1:0] x_c, y_c;
  gcpg_pkg::s1_t s1_d, s1_q;

  always_comb begin
    cur_row   = restart_i ? '0 : row_q;
    cur_col   = restart_i ? '0 : col_q;
    cur_line  = restart_i ? '0 : line_q;
    cur_pix   = restart_i ? '0 : pix_q;
    cur_org_x = restart_i ? '0 : org_x_q;
    cur_org_y = restart_i ? '0 : org_y_q;

    end_px  = ({1'b0, cur_pix} + (SW + 1)'(1)) >= {1'b0, w_eff};
    end_ln  = ({1'b0, cur_line} + (SW + 1)'(1)) >= {1'b0, h_eff};
    end_col = ({1'b0, cur_col} + (RW + 1)'(1)) >= {1'b0, rect_eff};
    end_row = ({1'b0, cur_row} + (RW + 1)'(1)) >= {1'b0, rect_eff};

    x_c = cur_org_x + CW'(cur_pix);
    y_c = cur_org_y + CW'(cur_line);

    s1_d.row  = cur_row;
    s1_d.col  = cur_col;
    s1_d.x    = gcpg_pkg::PIX_W'(x_c);
    s1_d.y    = gcpg_pkg::PIX_W'(y_c);
    s1_d.last = end_px && end_ln && end_col && end_row;

    row_d   = cur_row;
    col_d   = cur_col;
    line_d  = cur_line;
    pix_d   = cur_pix;
    org_x_d = cur_org_x;
    org_y_d = cur_org_y;
    if (!end_px) begin
      pix_d = cur_pix + SW'(1);
    end else begin
      pix_d = '0;
      if (!end_ln) begin
        line_d = cur_line + SW'(1);
      end else begin
        line_d = '0;
        if (!end_col) begin
          col_d   = cur_col + RW'(1);
          org_x_d = cur_org_x + CW'(w_eff);
        end else begin
          col_d   = '0;
          org_x_d = '0;
          if (!end_row) begin
            row_d   = cur_row + RW'(1);
            org_y_d = cur_org_y + CW'(h_eff);
          end else begin
            row_d   = '0;
            org_y_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      line_q  <= '0;
      pix_q   <= '0;
      org_x_q <= '0;
      org_y_q <= '0;
    end else if (in_acc) begin
      row_q   <= row_d;
      col_q   <= col_d;
      line_q  <= line_d;
      pix_q   <= pix_d;
      org_x_q <= org_x_d;
      org_y_q <= org_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_q <= s1_d;
  end

  // Stage 2: per-axis products
  gcpg_pkg::s2_t s2_d, s2_q;
  logic [gcpg_pkg::ADV_W-1:0] adv_sum;

  always_comb begin
    adv_sum        = gcpg_pkg::ADV_W'(s1_q.col) + gcpg_pkg::ADV_W'(s1_q.row);
    s2_d.row_rect  = s1_q.row * rect_eff;
    s2_d.col       = s1_q.col;
    s2_d.red_adv   = s1_q.col * step_q;
    s2_d.green_adv = s1_q.row * step_q;
    s2_d.blue_adv  = adv_sum * step_q;
    s2_d.x         = s1_q.x;
    s2_d.y         = s1_q.y;
    s2_d.last      = s1_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) s2_q <= s2_d;
  end

  // Stage 3: cell index times step, packed direct colour
  gcpg_pkg::s3_t s3_d, s3_q;
  logic [gcpg_pkg::PROD_W-1:0] cell_idx;

  always_comb begin
    cell_idx      = s2_q.row_rect + gcpg_pkg::PROD_W'(s2_q.col);
    s3_d.idx_prod = cell_idx * step_q;
    s3_d.direct   =
      gcpg_pkg::channel(first_q, layout_q[0*FW +: FW], layout_q[3*FW +: FW], s2_q.red_adv) |
      gcpg_pkg::channel(first_q, layout_q[1*FW +: FW], layout_q[4*FW +: FW], s2_q.green_adv) |
      gcpg_pkg::channel(first_q, layout_q[2*FW +: FW], layout_q[5*FW +: FW], s2_q.blue_adv);
    s3_d.x        = s2_q.x;
    s3_d.y        = s2_q.y;
    s3_d.last     = s2_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_v_q) s3_q <= s3_d;
  end

  // Output register
  logic [gcpg_pkg::COLOR_W-1:0] color_d;
  assign color_d = model_q ? s3_q.direct
                 : (first_q + gcpg_pkg::COLOR_W'(s3_q.idx_prod)) & gcpg_pkg::bpp_mask(bpp_q);

  always_ff @(posedge clk_i) begin
    if (out_rdy && s3_v_q) begin
      pixel_x_o     <= s3_q.x;
      pixel_y_o     <= s3_q.y;
      pixel_color_o <= color_d;
      frame_last_o  <= s3_q.last;
    end
  end

  assign out_valid_o = out_v_q;

  // An empty output register never holds back requests
  a_no_stall_when_drained: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !out_v_q |-> !in_stall_o
  ) else $error("request stalled with an empty output register");

  // A restart request produces the first pixel of the grid
  a_restart_origin: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_acc && restart_i |=>
      s1_q.row == '0 && s1_q.col == '0 && s1_q.x == '0 && s1_q.y == '0
  ) else $error("restart did not return to the first pixel");

  // After the last pixel of the frame the walk is back at the start
  a_frame_wrap: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_acc && s1_d.last |=>
      row_q == '0 && col_q == '0 && line_q == '0 && pix_q == '0 &&
      org_x_q == '0 && org_y_q == '0
  ) else $error("walk did not wrap after the last pixel");

endmodule
